// ===== sv/shist_pkg.sv =====
// Shared types, codes and constants for the saturating 3-D histogram.
`default_nettype none
package shist_pkg;

  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 5;
  localparam int COUNT_W    = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OFFS_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * SIZE_W;
  // widest bin index sum with sizes up to 31: 30*961 + 30*31 + 30 < 2^15
  localparam int CALC_W     = 15;

  localparam logic [COUNT_W-1:0] LIMIT_8  = 32'd255;
  localparam logic [COUNT_W-1:0] LIMIT_16 = 32'd65535;
  localparam logic [COUNT_W-1:0] LIMIT_32 = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_OFFS,
    S_INDEX,
    S_READ,
    S_UPDATE
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_SIZE_X     = 3'd3,
    REG_SIZE_Y     = 3'd4,
    REG_SIZE_Z     = 3'd5,
    REG_COUNT_MODE = 3'd6
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_DOUBLE  = 2'd0,
    MODE_COUNT8  = 2'd1,
    MODE_COUNT16 = 2'd2,
    MODE_COUNT32 = 2'd3
  } count_mode_e;

  typedef struct packed {
    logic capture;
    logic calc_offs;
    logic calc_idx;
    logic mem_rd;
    logic update;
    logic clr_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== sv/shist_if.sv =====
// Handshake channels of the histogram: sample input, result output, register writes.
`default_nettype none
interface shist_in_if;
  import shist_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] z_coord;
  modport source (output valid, action, x_coord, y_coord, z_coord, input ready);
  modport sink   (input valid, action, x_coord, y_coord, z_coord, output ready);
endinterface

interface shist_out_if;
  import shist_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] bin_count;
  logic               in_range;
  logic               point_lost;
  logic [COUNT_W-1:0] lost_total;
  modport source (output valid, bin_count, in_range, point_lost, lost_total, input ready);
  modport sink   (input valid, bin_count, in_range, point_lost, lost_total, output ready);
endinterface

interface shist_cfg_if;
  import shist_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/shist_ctrl.sv =====
// Sequencer of the histogram: clearing pass, then one beat at a time through the datapath.
`default_nettype none
module shist_ctrl import shist_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (sts_i.clr_last) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_OFFS;
      S_OFFS:   state_d = S_INDEX;
      S_INDEX:  state_d = S_READ;
      S_READ:   state_d = S_UPDATE;
      S_UPDATE: if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_CLEAR: cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_OFFS:   cmd_o.calc_offs = 1'b1;
      S_INDEX:  cmd_o.calc_idx  = 1'b1;
      S_READ:   cmd_o.mem_rd    = 1'b1;
      S_UPDATE: cmd_o.update    = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  a_clear_ends_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && state_d != S_CLEAR) |-> sts_i.clr_last)
    else $error("clearing pass left early");

  a_offs_then_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OFFS) |=> (state_q == S_INDEX))
    else $error("offset stage not followed by index stage");

endmodule
`default_nettype wire

// ===== sv/shist_dp.sv =====
// Histogram datapath: registers, offset and index arithmetic, bin memory, counters, result register.
`default_nettype none
module shist_dp import shist_pkg::*; #(
  parameter int MAX_BINS_X = 16,
  parameter int MAX_BINS_Y = 16,
  parameter int MAX_BINS_Z = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  output dp_sts_t                   sts_o,
  input  logic                      action_i,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  input  logic signed [COORD_W-1:0] z_coord_i,
  input  logic                      cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [COUNT_W-1:0]        bin_count_o,
  output logic                      in_range_o,
  output logic                      point_lost_o,
  output logic [COUNT_W-1:0]        lost_total_o
);

  localparam int DEPTH  = MAX_BINS_X * MAX_BINS_Y * MAX_BINS_Z;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] s, int mx);
    logic [SIZE_W-1:0] r;
    r = s;
    if (int'(s) > mx) r = SIZE_W'(mx);
    return r;
  endfunction

  function automatic logic [OFFS_W-1:0] axis_diff(logic [COORD_W-1:0] c,
                                                  logic [COORD_W-1:0] o);
    return {c[COORD_W-1], c} - {o[COORD_W-1], o};
  endfunction

  function automatic logic [COUNT_W-1:0] mode_limit(logic [MODE_W-1:0] m);
    logic [COUNT_W-1:0] r;
    case (count_mode_e'(m))
      MODE_COUNT8:  r = LIMIT_8;
      MODE_COUNT16: r = LIMIT_16;
      default:      r = LIMIT_32;
    endcase
    return r;
  endfunction

  // configuration registers
  logic [COORD_W-1:0] origin_x_q, origin_y_q, origin_z_q;
  logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
  logic [MODE_W-1:0]  count_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      origin_z_q   <= '0;
      size_x_q     <= SIZE_W'(16);
      size_y_q     <= SIZE_W'(16);
      size_z_q     <= SIZE_W'(16);
      count_mode_q <= MODE_DOUBLE;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ORIGIN_X:   origin_x_q   <= cfg_data_i[COORD_W-1:0];
        REG_ORIGIN_Y:   origin_y_q   <= cfg_data_i[COORD_W-1:0];
        REG_ORIGIN_Z:   origin_z_q   <= cfg_data_i[COORD_W-1:0];
        REG_SIZE_X:     size_x_q     <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Y:     size_y_q     <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Z:     size_z_q     <= cfg_data_i[SIZE_W-1:0];
        REG_COUNT_MODE: count_mode_q <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] sx, sy, sz;
  assign sx = clamp_size(size_x_q, MAX_BINS_X);
  assign sy = clamp_size(size_y_q, MAX_BINS_Y);
  assign sz = clamp_size(size_z_q, MAX_BINS_Z);

  // captured beat
  logic               act_q;
  logic [COORD_W-1:0] x_q, y_q, z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      x_q   <= x_coord_i;
      y_q   <= y_coord_i;
      z_q   <= z_coord_i;
    end
  end

  // offsets and range test
  logic [OFFS_W-1:0] dx, dy, dz;
  logic              ok_x, ok_y, ok_z;
  logic [SIZE_W-1:0] xo_q, yo_q, zo_q;
  logic [PROD_W-1:0] sxy_q;
  logic              inside_q;

  assign dx   = axis_diff(x_q, origin_x_q);
  assign dy   = axis_diff(y_q, origin_y_q);
  assign dz   = axis_diff(z_q, origin_z_q);
  assign ok_x = !dx[OFFS_W-1] && (dx < OFFS_W'(sx));
  assign ok_y = !dy[OFFS_W-1] && (dy < OFFS_W'(sy));
  assign ok_z = !dz[OFFS_W-1] && (dz < OFFS_W'(sz));

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_offs) begin
      xo_q     <= dx[SIZE_W-1:0];
      yo_q     <= dy[SIZE_W-1:0];
      zo_q     <= dz[SIZE_W-1:0];
      sxy_q    <= PROD_W'(sx) * PROD_W'(sy);
      inside_q <= ok_x && ok_y && ok_z;
    end
  end

  // bin index z*sx*sy + y*sx + x; only meaningful when inside
  logic [CALC_W-1:0] idx_calc;
  logic [ADDR_W-1:0] idx_q;

  assign idx_calc = CALC_W'(zo_q) * CALC_W'(sxy_q) + CALC_W'(yo_q) * CALC_W'(sx)
                  + CALC_W'(xo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_idx) begin
      idx_q <= inside_q ? ADDR_W'(idx_calc) : '0;
    end
  end

  // clearing pass address
  logic [ADDR_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // bin memory, single read-modify-write per beat
  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] rd_q;
  logic               is_add, full, bump;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [COUNT_W-1:0] mem_wd;

  assign is_add = !act_q;
  assign full   = rd_q >= mode_limit(count_mode_q);
  assign bump   = inside_q && is_add && !full;
  assign mem_we = cmd_i.clr_wr || (cmd_i.update && bump);
  assign mem_wa = cmd_i.clr_wr ? clr_q : idx_q;
  assign mem_wd = cmd_i.clr_wr ? '0 : rd_q + COUNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.mem_rd) rd_q <= mem[idx_q];
  end

  // loss counter
  logic               lost;
  logic [COUNT_W-1:0] lost_q, lost_d;

  assign lost   = inside_q && is_add && full;
  assign lost_d = (lost && lost_q != LIMIT_32) ? lost_q + COUNT_W'(1) : lost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_q <= '0;
    end else if (cmd_i.update) begin
      lost_q <= lost_d;
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      bin_count_o  <= !inside_q ? '0 : (bump ? rd_q + COUNT_W'(1) : rd_q);
      in_range_o   <= inside_q;
      point_lost_o <= lost;
      lost_total_o <= lost_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.clr_last = (clr_q == ADDR_W'(DEPTH - 1));

  a_loss_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> lost_q >= $past(lost_q))
    else $error("loss counter went down");

  a_lost_needs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && point_lost_o) |-> in_range_o)
    else $error("lost point outside the bins");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !in_range_o) |-> (bin_count_o == '0))
    else $error("nonzero count for point outside the bins");

  a_valid_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.update))
    else $error("result valid without an update");

endmodule
`default_nettype wire

// ===== sv/saturating_3d_histogram_core.sv =====
// Top level of the saturating 3-D histogram: sequencer plus datapath on three channels.
`default_nettype none
// Counts (x,y,z) sample beats into MAX_BINS_X*MAX_BINS_Y*MAX_BINS_Z bins of 32 bits and
// answers bin reads; every input beat yields exactly one result beat. Each item steps
// through capture, offset/range test, index multiply, memory read and update, in that
// order; a new beat is taken only after the last has done its update, which stalls
// while the output register holds an untaken result. A finished result waits in the
// output register while the next item proceeds. After reset a clearing pass zeroes
// the bins; no sample is taken during it, register writes are. Register writes are
// always ready and take effect at once.
module saturating_3d_histogram_core import shist_pkg::*; #(
  parameter int MAX_BINS_X = 16,
  parameter int MAX_BINS_Y = 16,
  parameter int MAX_BINS_Z = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  shist_in_if.sink           in_i,
  shist_out_if.source        out_o,
  shist_cfg_if.sink          cfg_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  shist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  shist_dp #(
    .MAX_BINS_X (MAX_BINS_X),
    .MAX_BINS_Y (MAX_BINS_Y),
    .MAX_BINS_Z (MAX_BINS_Z)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (in_i.action),
    .x_coord_i    (in_i.x_coord),
    .y_coord_i    (in_i.y_coord),
    .z_coord_i    (in_i.z_coord),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .bin_count_o  (out_o.bin_count),
    .in_range_o   (out_o.in_range),
    .point_lost_o (out_o.point_lost),
    .lost_total_o (out_o.lost_total)
  );

endmodule
`default_nettype wire

// ===== sim/saturating_3d_histogram_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for saturating_3d_histogram_core: directed and random sample streams.
module saturating_3d_histogram_core_tb;
  import shist_pkg::*;

  localparam int BINS_X = 16;
  localparam int BINS_Y = 16;
  localparam int BINS_Z = 16;
  localparam int STORE_DEPTH = BINS_X * BINS_Y * BINS_Z;
  localparam int SETTLE_CYCLES = 12;
  localparam int RUN_LIMIT_NS = 400000;
  localparam int MAX_REPORTS = 40;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 65;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;
  // index past the register list, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic               in_range;
    logic               point_lost;
    logic [COUNT_W-1:0] lost_total;
  } hist_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_LIGHT
  } rx_style_e;

  logic clk_i;
  logic rst_ni;

  shist_in_if  in_bus ();
  shist_out_if out_bus ();
  shist_cfg_if cfg_bus ();

  saturating_3d_histogram_core #(
    .MAX_BINS_X(BINS_X),
    .MAX_BINS_Y(BINS_Y),
    .MAX_BINS_Z(BINS_Z)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  // mirror of the block's registers and storage
  logic [COUNT_W-1:0]        bin_mem [STORE_DEPTH];
  logic [COUNT_W-1:0]        drop_count;
  logic [COORD_W-1:0]        org_x, org_y, org_z;
  logic [SIZE_W-1:0]         dim_x, dim_y, dim_z;
  count_mode_e               cnt_mode;

  hist_result_t pending_results[$];
  hist_result_t oldest_result;
  int           mismatch_count = 0;
  int           burst_left = 0;
  int           stall_left = 0;
  rx_style_e    rx_style = RX_OPEN;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int eff_size(logic [SIZE_W-1:0] s, int lim);
    return (int'(s) > lim) ? lim : int'(s);
  endfunction

  function automatic int axis_delta(logic [COORD_W-1:0] c, logic [COORD_W-1:0] o);
    return int'($signed(c)) - int'($signed(o));
  endfunction

  function automatic hist_result_t predict_bin_result(logic act, logic [COORD_W-1:0] x,
                                                      logic [COORD_W-1:0] y,
                                                      logic [COORD_W-1:0] z);
    hist_result_t       r;
    int                 sx, sy, sz, dx, dy, dz, idx;
    logic [COUNT_W-1:0] cap;
    r = '0;
    sx = eff_size(dim_x, BINS_X);
    sy = eff_size(dim_y, BINS_Y);
    sz = eff_size(dim_z, BINS_Z);
    dx = axis_delta(x, org_x);
    dy = axis_delta(y, org_y);
    dz = axis_delta(z, org_z);
    case (cnt_mode)
      MODE_COUNT8:  cap = LIMIT_8;
      MODE_COUNT16: cap = LIMIT_16;
      MODE_DOUBLE:  cap = LIMIT_32;
      default:      cap = LIMIT_32;
    endcase
    if (dx >= 0 && dx < sx && dy >= 0 && dy < sy && dz >= 0 && dz < sz) begin
      idx = dz * sx * sy + dy * sx + dx;
      r.in_range = 1'b1;
      if (act == ACT_ADD) begin
        // a bin at or above the limit is full, even after the limit was lowered
        if (bin_mem[idx] >= cap) begin
          r.point_lost = 1'b1;
          if (drop_count != LIMIT_32) drop_count = drop_count + 1;
        end else begin
          bin_mem[idx] = bin_mem[idx] + 1;
        end
      end
      r.bin_count = bin_mem[idx];
    end
    r.lost_total = drop_count;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] org,
                                                    logic [SIZE_W-1:0] dim, int lim);
    int span;
    span = eff_size(dim, lim);
    case ($urandom_range(0, 9))
      0: return COORD_W'($urandom);
      1: return org - 16'd1;
      2: return org + COORD_W'(span);
      default: return (span == 0) ? org : org + COORD_W'($urandom_range(0, span - 1));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 5'd0;
      1:       return SIZE_W'($urandom_range(17, 31));
      2, 3, 4: return 5'd16;
      default: return SIZE_W'($urandom_range(1, 8));
    endcase
  endfunction

  // one sample beat; valid is left high so the next beat of a burst follows at once
  task automatic push_sample(input logic act, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_bus.valid   <= 1'b1;
    in_bus.action  <= act;
    in_bus.x_coord <= x;
    in_bus.y_coord <= y;
    in_bus.z_coord <= z;
    do @(posedge clk_i); while (!in_bus.ready);
    pending_results.push_back(predict_bin_result(act, x, y, z));
  endtask

  task automatic settle_block();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_ORIGIN_X:   org_x = val;
      REG_ORIGIN_Y:   org_y = val;
      REG_ORIGIN_Z:   org_z = val;
      REG_SIZE_X:     dim_x = val[SIZE_W-1:0];
      REG_SIZE_Y:     dim_y = val[SIZE_W-1:0];
      REG_SIZE_Z:     dim_z = val[SIZE_W-1:0];
      REG_COUNT_MODE: cnt_mode = count_mode_e'(val[MODE_W-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // upper data bits above each field are random and must be ignored
  task automatic write_all_regs(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                                input logic [COORD_W-1:0] oz, input logic [SIZE_W-1:0] sx,
                                input logic [SIZE_W-1:0] sy, input logic [SIZE_W-1:0] sz,
                                input count_mode_e mode);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_SIZE_X, {11'($urandom), sx});
    write_reg(REG_SIZE_Y, {11'($urandom), sy});
    write_reg(REG_SIZE_Z, {11'($urandom), sz});
    write_reg(REG_COUNT_MODE, {14'($urandom), mode});
  endtask

  // reset geometry: corners, repeats, out-of-range points, read of an untouched bin
  task automatic test_corner_points();
    push_sample(ACT_ADD, 16'd0, 16'd0, 16'd0);
    push_sample(ACT_ADD, 16'd0, 16'd0, 16'd0);
    push_sample(ACT_ADD, 16'd15, 16'd15, 16'd15);
    push_sample(ACT_ADD, 16'd15, 16'd0, 16'd0);
    push_sample(ACT_ADD, 16'd0, 16'd15, 16'd0);
    push_sample(ACT_ADD, 16'd0, 16'd0, 16'd15);
    push_sample(ACT_READ, 16'd0, 16'd0, 16'd0);
    push_sample(ACT_READ, 16'd15, 16'd15, 16'd15);
    push_sample(ACT_READ, 16'd7, 16'd3, 16'd9);
    push_sample(ACT_ADD, 16'd16, 16'd0, 16'd0);
    push_sample(ACT_ADD, 16'd0, 16'hFFFF, 16'd0);
    push_sample(ACT_ADD, 16'd0, 16'd0, 16'd16);
    push_sample(ACT_ADD, 16'h8000, 16'h8000, 16'h8000);
    push_sample(ACT_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_sample(ACT_READ, 16'd16, 16'd16, 16'd16);
  endtask

  // most negative and most positive origins: wide offsets must not wrap into range
  task automatic test_origin_extremes();
    settle_block();
    write_all_regs(16'h8000, 16'h8000, 16'h8000, 5'd16, 5'd16, 5'd16, MODE_COUNT32);
    push_sample(ACT_ADD, 16'h8000, 16'h8000, 16'h8000);
    push_sample(ACT_ADD, 16'h800F, 16'h800F, 16'h800F);
    push_sample(ACT_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_sample(ACT_READ, 16'h8000, 16'h8000, 16'h8000);
    settle_block();
    write_all_regs(16'h7FFF, 16'h7FFF, 16'h7FFF, 5'd16, 5'd16, 5'd16, MODE_DOUBLE);
    push_sample(ACT_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_sample(ACT_ADD, 16'h8000, 16'h8000, 16'h8000);
    push_sample(ACT_ADD, 16'h7FFE, 16'h7FFF, 16'h7FFF);
    push_sample(ACT_READ, 16'h7FFF, 16'h7FFF, 16'h7FFF);
  endtask

  // zero size, sizes above the maximum, dropped write to an unused index
  task automatic test_size_edges();
    settle_block();
    write_all_regs(16'd0, 16'd0, 16'd0, 5'd0, 5'd16, 5'd16, MODE_COUNT32);
    push_sample(ACT_ADD, 16'd0, 16'd0, 16'd0);
    push_sample(ACT_READ, 16'd0, 16'd5, 16'd5);
    settle_block();
    write_reg(REG_SIZE_X, {11'($urandom), 5'd31});
    write_reg(REG_SIZE_Y, {11'($urandom), 5'd17});
    write_reg(REG_SIZE_Z, {11'($urandom), 5'd1});
    push_sample(ACT_ADD, 16'd15, 16'd15, 16'd0);
    push_sample(ACT_ADD, 16'd16, 16'd0, 16'd0);
    push_sample(ACT_ADD, 16'd0, 16'd16, 16'd0);
    push_sample(ACT_ADD, 16'd0, 16'd0, 16'd1);
    push_sample(ACT_ADD, 16'd30, 16'd3, 16'd0);
    settle_block();
    write_reg(REG_UNUSED, 16'($urandom));
    push_sample(ACT_READ, 16'd15, 16'd15, 16'd0);
    push_sample(ACT_ADD, 16'd3, 16'd2, 16'd0);
  endtask

  // single-bin geometry, 8-bit limit: fill the bin past full and keep losing points
  task automatic test_bin_saturation();
    logic [COORD_W-1:0] ox, oy, oz;
    settle_block();
    ox = COORD_W'($urandom);
    oy = COORD_W'($urandom);
    oz = COORD_W'($urandom);
    write_all_regs(ox, oy, oz, 5'd1, 5'd1, 5'd1, MODE_COUNT8);
    for (int i = 0; i < 300; i++) begin
      if (i % 40 == 39) push_sample(ACT_READ, ox, oy, oz);
      else if (i % 53 == 52) push_sample(ACT_ADD, ox + 16'd1, oy, oz);
      else push_sample(ACT_ADD, ox, oy, oz);
    end
  endtask

  // raise the limit, then lower it below the bin's value: bin keeps its count
  task automatic test_limit_lowered();
    settle_block();
    write_reg(REG_COUNT_MODE, {14'($urandom), MODE_COUNT32});
    repeat (20) push_sample(ACT_ADD, org_x, org_y, org_z);
    settle_block();
    write_reg(REG_COUNT_MODE, {14'($urandom), MODE_DOUBLE});
    repeat (5) push_sample(ACT_ADD, org_x, org_y, org_z);
    settle_block();
    write_reg(REG_COUNT_MODE, {14'($urandom), MODE_COUNT8});
    repeat (5) push_sample(ACT_ADD, org_x, org_y, org_z);
    push_sample(ACT_READ, org_x, org_y, org_z);
    settle_block();
    write_reg(REG_COUNT_MODE, {14'($urandom), MODE_COUNT16});
    repeat (3) push_sample(ACT_ADD, org_x, org_y, org_z);
    push_sample(ACT_READ, org_x, org_y, org_z);
  endtask

  // random geometries and modes; points repeat often to hit back-to-back updates
  task automatic test_random_traffic();
    logic [COORD_W-1:0] px, py, pz;
    logic               act;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_block();
      write_all_regs(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     pick_size(), pick_size(), pick_size(),
                     count_mode_e'($urandom_range(0, 3)));
      px = pick_coord(org_x, dim_x, BINS_X);
      py = pick_coord(org_y, dim_y, BINS_Y);
      pz = pick_coord(org_z, dim_z, BINS_Z);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) >= 3) begin
          px = pick_coord(org_x, dim_x, BINS_X);
          py = pick_coord(org_y, dim_y, BINS_Y);
          pz = pick_coord(org_z, dim_z, BINS_Z);
        end
        act = ($urandom_range(0, 3) == 0) ? ACT_READ : ACT_ADD;
        push_sample(act, px, py, pz);
      end
    end
  endtask

  initial begin
    foreach (bin_mem[i]) bin_mem[i] = '0;
    drop_count = '0;
    org_x = '0;
    org_y = '0;
    org_z = '0;
    dim_x = 5'd16;
    dim_y = 5'd16;
    dim_z = 5'd16;
    cnt_mode = MODE_DOUBLE;
    rst_ni         <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.action  <= ACT_ADD;
    in_bus.x_coord <= '0;
    in_bus.y_coord <= '0;
    in_bus.z_coord <= '0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= REG_ORIGIN_X;
    cfg_bus.data   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_points();
    test_origin_extremes();
    test_size_edges();
    test_bin_saturation();
    test_limit_lowered();
    test_random_traffic();
    settle_block();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side stalls in styles that change whenever a random hold counter runs out
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      rx_style   <= rx_style_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (rx_style)
      RX_OPEN:   out_bus.ready <= 1'b1;
      RX_COIN:   out_bus.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_bus.ready <= (stall_left[1:0] == 2'b00);
      default:   out_bus.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic flag_field(input string name, input logic [COUNT_W-1:0] want,
                            input logic [COUNT_W-1:0] got);
    if (want !== got) begin
      if (mismatch_count < MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: result beat with none expected, expected none actual %0h",
                   $time, out_bus.bin_count);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        flag_field("bin_count", oldest_result.bin_count, out_bus.bin_count);
        flag_field("in_range", COUNT_W'(oldest_result.in_range), COUNT_W'(out_bus.in_range));
        flag_field("point_lost", COUNT_W'(oldest_result.point_lost),
                   COUNT_W'(out_bus.point_lost));
        flag_field("lost_total", oldest_result.lost_total, out_bus.lost_total);
      end
    end
  end

endmodule
